/* rtl/ort_pkg.sv */
package ort_pkg;

   localparam int CAPACITY   = 128;
   localparam int NAME_BYTES = 20;

   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 8;
   localparam int POS_W    = 8;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LOCATE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [31:0] id;
      logic [63:0] name_low;
      logic [63:0] name_mid;
      logic [31:0] name_high;
      logic [31:0] score;
   } record_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      record_type       data;
   } ram_write_type;

   // Keeps the name bytes below NAME_BYTES in the 8-byte chunk that starts at byte first.
   function automatic logic [63:0] name_mask(input int first);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (first + b < NAME_BYTES) begin
            m[8*b +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   localparam logic [63:0] NAME_MASK_LOW  = name_mask(0);
   localparam logic [63:0] NAME_MASK_MID  = name_mask(8);
   localparam logic [63:0] NAME_MASK_HIGH = name_mask(16);

endpackage

/* rtl/ort_if.sv */
interface ort_req_if;
   import ort_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [POS_W-1:0]    position;
   logic signed [31:0]  record_id;
   logic [63:0]         name_low;
   logic [63:0]         name_mid;
   logic [31:0]         name_high;
   logic [31:0]         score_bits;

   modport source (
      output valid, kind, position, record_id, name_low, name_mid, name_high, score_bits,
      input  ready
   );
   modport sink (
      input  valid, kind, position, record_id, name_low, name_mid, name_high, score_bits,
      output ready
   );
endinterface

interface ort_rsp_if;
   import ort_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    found_position;
   logic [CNT_W-1:0]    entry_total;
   logic signed [31:0]  out_id;
   logic [63:0]         out_name_low;
   logic [63:0]         out_name_mid;
   logic [31:0]         out_name_high;
   logic [31:0]         out_score_bits;

   modport source (
      output valid, status, found_position, entry_total, out_id, out_name_low,
             out_name_mid, out_name_high, out_score_bits,
      input  ready
   );
   modport sink (
      input  valid, status, found_position, entry_total, out_id, out_name_low,
             out_name_mid, out_name_high, out_score_bits,
      output ready
   );
endinterface

/* rtl/ort_ram.sv */
module ort_ram (
   input  logic                      clock,
   input  ort_pkg::ram_write_type    wr,
   input  logic [ort_pkg::IDX_W-1:0] rd_addr,
   output ort_pkg::record_type       rd_data
);
   import ort_pkg::*;

   record_type mem_ff [CAPACITY];
   record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ort_ctrl.sv */
module ort_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   ort_req_if.sink                   req_ch,
   ort_rsp_if.source                 rsp_ch,
   output ort_pkg::ram_write_type    ram_wr,
   output logic [ort_pkg::IDX_W-1:0] rd_addr,
   input  ort_pkg::record_type       rd_data
);
   import ort_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   record_type          rec_ff, rec_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                lag_valid_ff, lag_valid_in;
   logic [IDX_W-1:0]    lag_idx_ff, lag_idx_in;
   logic [POS_W-1:0]    found_ff, found_in;
   record_type          out_rec_ff, out_rec_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]    rsp_total_ff, rsp_total_in;
   record_type          rsp_rec_ff, rsp_rec_in;

   logic full;
   logic pos_bad;
   logic pos_bad_ins;
   logic issue;
   logic match;

   assign full        = count_ff >= CNT_W'(CAPACITY);
   assign pos_bad     = (req_ch.position == '0) || (req_ch.position > count_ff);
   assign pos_bad_ins = (req_ch.position == '0) ||
                        ({1'b0, req_ch.position} > ({1'b0, count_ff} + 9'd1));

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rd_addr      = idx_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      rec_in        = rec_ff;
      status_in     = status_ff;
      remain_in     = remain_ff;
      idx_in        = idx_ff;
      lag_valid_in  = 1'b0;
      lag_idx_in    = lag_idx_ff;
      found_in      = found_ff;
      out_rec_in    = out_rec_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_rec_in    = rsp_rec_ff;
      ram_wr.en     = 1'b0;
      ram_wr.addr   = '0;
      ram_wr.data   = rec_ff;
      issue         = 1'b0;
      match         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               kind_in            = req_ch.kind;
               pos_in             = req_ch.position;
               rec_in.id          = $unsigned(req_ch.record_id);
               rec_in.name_low    = req_ch.name_low & NAME_MASK_LOW;
               rec_in.name_mid    = req_ch.name_mid & NAME_MASK_MID;
               rec_in.name_high   = req_ch.name_high & NAME_MASK_HIGH[31:0];
               rec_in.score       = req_ch.score_bits;
               found_in           = '0;
               out_rec_in         = '0;
               remain_in          = '0;
               status_in          = STATUS_OK;
               state_in           = ST_FINISH;
               case (req_ch.kind)
                  KIND_APPEND: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end
                  end
                  KIND_INSERT: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else if (pos_bad_ins) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        // Walk from the last entry down to the insert point.
                        remain_in = count_ff - req_ch.position + CNT_W'(1);
                        idx_in    = count_ff[IDX_W-1:0] - IDX_W'(1);
                        state_in  = ST_SCAN;
                     end
                  end
                  KIND_DELETE: begin
                     if (pos_bad) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        remain_in = count_ff - req_ch.position;
                        idx_in    = req_ch.position[IDX_W-1:0];
                        state_in  = ST_SCAN;
                     end
                  end
                  KIND_LOCATE: begin
                     status_in = STATUS_NOTFOUND;
                     remain_in = count_ff;
                     idx_in    = '0;
                     state_in  = ST_SCAN;
                  end
                  KIND_READ: begin
                     if (pos_bad) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        remain_in = CNT_W'(1);
                        idx_in    = req_ch.position[IDX_W-1:0] - IDX_W'(1);
                        state_in  = ST_SCAN;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // The entry read in the previous cycle is acted on now.
            if (lag_valid_ff) begin
               case (kind_ff)
                  KIND_INSERT: begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = lag_idx_ff + IDX_W'(1);
                     ram_wr.data = rd_data;
                  end
                  KIND_DELETE: begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = lag_idx_ff - IDX_W'(1);
                     ram_wr.data = rd_data;
                  end
                  KIND_LOCATE: begin
                     if (rd_data.id == rec_ff.id) begin
                        match     = 1'b1;
                        status_in = STATUS_OK;
                        found_in  = POS_W'(lag_idx_ff) + POS_W'(1);
                     end
                  end
                  KIND_READ: begin
                     out_rec_in = rd_data;
                  end
                  default: begin
                  end
               endcase
            end
            issue = (remain_ff != '0) && !match;
            if (issue) begin
               lag_valid_in = 1'b1;
               lag_idx_in   = idx_ff;
               remain_in    = remain_ff - CNT_W'(1);
               if (kind_ff == KIND_INSERT) begin
                  idx_in = idx_ff - IDX_W'(1);
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               if (status_ff == STATUS_OK) begin
                  case (kind_ff)
                     KIND_APPEND: begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = count_ff[IDX_W-1:0];
                        count_in    = count_ff + CNT_W'(1);
                     end
                     KIND_INSERT: begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = pos_ff[IDX_W-1:0] - IDX_W'(1);
                        count_in    = count_ff + CNT_W'(1);
                     end
                     KIND_DELETE: begin
                        count_in = count_ff - CNT_W'(1);
                     end
                     default: begin
                     end
                  endcase
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_total_in  = count_in;
               rsp_rec_in    = out_rec_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         lag_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lag_valid_ff <= lag_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      pos_ff        <= pos_in;
      rec_ff        <= rec_in;
      status_ff     <= status_in;
      remain_ff     <= remain_in;
      idx_ff        <= idx_in;
      lag_idx_ff    <= lag_idx_in;
      found_ff      <= found_in;
      out_rec_ff    <= out_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_rec_ff    <= rsp_rec_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.found_position = rsp_found_ff;
   assign rsp_ch.entry_total    = rsp_total_ff;
   assign rsp_ch.out_id         = $signed(rsp_rec_ff.id);
   assign rsp_ch.out_name_low   = rsp_rec_ff.name_low;
   assign rsp_ch.out_name_mid   = rsp_rec_ff.name_mid;
   assign rsp_ch.out_name_high  = rsp_rec_ff.name_high;
   assign rsp_ch.out_score_bits = rsp_rec_ff.score;

endmodule

/* rtl/ordered_record_table_unit.sv */
// Append, unused kinds and rejected requests go from the request beat to the finish state;
// read, insert, delete and locate first pass a scan that reads, moves or compares entries,
// at most the entry count of them. The response is registered in the finish state.
// One request is in work at a time; the single read port of the record memory sets the pace
// of one entry per cycle. Synchronous reset empties the list; the memory itself is not cleared.
module ordered_record_table_unit (
   input  logic      clock,
   input  logic      reset,
   ort_req_if.sink   req_ch,
   ort_rsp_if.source rsp_ch
);
   import ort_pkg::*;

   ram_write_type    ram_wr;
   logic [IDX_W-1:0] rd_addr;
   record_type       rd_data;

   ort_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .ram_wr  (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ort_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

/* tb/ort_reply_checker.sv */
module ort_reply_checker (
   input  logic        clock,
   input  logic        reset,
   ort_req_if          req_ch,
   ort_rsp_if          rsp_ch,
   output int unsigned error_count,
   output int unsigned replies_owed
);
   import ort_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    found_position;
      logic [CNT_W-1:0]    entry_total;
      record_type          entry;
   } reply_type;

   record_type stored_rows [CAPACITY];
   int         stored_count;
   reply_type  awaited_replies [$];
   reply_type  wanted;

   task automatic log_error(input string msg);
      $display("[%0t] error: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string field, input logic [63:0] seen,
                              input logic [63:0] expected_value);
      if (seen !== expected_value) begin
         log_error($sformatf("%s is %h, expected %h", field, seen, expected_value));
      end
   endtask

   // Bytes of a name chunk at or beyond NAME_BYTES are stored as zero.
   function automatic logic [63:0] name_keep(input int first_byte);
      int kept;
      kept = NAME_BYTES - first_byte;
      if (kept <= 0) return '0;
      if (kept >= 8) return '1;
      return (64'd1 << (8 * kept)) - 64'd1;
   endfunction

   function automatic record_type take_record();
      record_type  rec;
      logic [63:0] high_keep;
      high_keep     = name_keep(16);
      rec.id        = req_ch.record_id;
      rec.name_low  = req_ch.name_low & name_keep(0);
      rec.name_mid  = req_ch.name_mid & name_keep(8);
      rec.name_high = req_ch.name_high & high_keep[31:0];
      rec.score     = req_ch.score_bits;
      return rec;
   endfunction

   // Applies one request to the local copy of the list and returns the reply it must produce.
   function automatic reply_type serve_request(input logic [KIND_W-1:0] kind,
                                               input logic [POS_W-1:0] pos,
                                               input record_type rec);
      reply_type r;
      int        p;
      r = '0;
      p = int'(pos);
      case (kind)
         KIND_APPEND: begin
            if (stored_count >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               stored_rows[stored_count] = rec;
               stored_count++;
            end
         end
         KIND_INSERT: begin
            if (stored_count >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else if (p < 1 || p > stored_count + 1) begin
               r.status = STATUS_RANGE;
            end else begin
               for (int i = stored_count; i >= p; i--) begin
                  stored_rows[i] = stored_rows[i-1];
               end
               stored_rows[p-1] = rec;
               stored_count++;
            end
         end
         KIND_DELETE: begin
            if (p < 1 || p > stored_count) begin
               r.status = STATUS_RANGE;
            end else begin
               for (int i = p; i < stored_count; i++) begin
                  stored_rows[i-1] = stored_rows[i];
               end
               stored_count--;
            end
         end
         KIND_LOCATE: begin
            r.status = STATUS_NOTFOUND;
            for (int i = 0; i < stored_count; i++) begin
               if (stored_rows[i].id == rec.id) begin
                  r.status         = STATUS_OK;
                  r.found_position = POS_W'(i + 1);
                  break;
               end
            end
         end
         KIND_READ: begin
            if (p < 1 || p > stored_count) begin
               r.status = STATUS_RANGE;
            end else begin
               r.entry = stored_rows[p-1];
            end
         end
         default: begin
         end
      endcase
      r.entry_total = CNT_W'(stored_count);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         stored_count = 0;
         error_count  = 0;
         awaited_replies.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_replies.size() == 0) begin
               log_error("result beat with no request waiting for it");
            end else begin
               wanted = awaited_replies.pop_front();
               check_field("status", rsp_ch.status, wanted.status);
               check_field("found_position", rsp_ch.found_position, wanted.found_position);
               check_field("entry_total", rsp_ch.entry_total, wanted.entry_total);
               check_field("out_id", $unsigned(rsp_ch.out_id), wanted.entry.id);
               check_field("out_name_low", rsp_ch.out_name_low, wanted.entry.name_low);
               check_field("out_name_mid", rsp_ch.out_name_mid, wanted.entry.name_mid);
               check_field("out_name_high", rsp_ch.out_name_high, wanted.entry.name_high);
               check_field("out_score_bits", rsp_ch.out_score_bits, wanted.entry.score);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            awaited_replies.push_back(serve_request(req_ch.kind, req_ch.position,
                                                    take_record()));
         end
      end
      replies_owed = awaited_replies.size();
   end

endmodule

/* tb/tb_top.sv */
module tb_top;
   import ort_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   localparam int TIMEOUT_CYCLES   = 400000;
   localparam int SETTLE_CYCLES    = 150;
   localparam int LONG_HOLD_CYCLES = 400;

   logic        clock;
   logic        reset;
   int unsigned error_count;
   int unsigned replies_owed;
   int unsigned cycle_count = 0;
   int unsigned hold_request;
   int          list_size;
   bit          calm;

   ort_req_if req_ch();
   ort_rsp_if rsp_ch();

   ordered_record_table_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ort_reply_checker reply_check (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .error_count  (error_count),
      .replies_owed (replies_owed)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Ids come mostly from a small pool so that locate requests find matches.
   function automatic logic [31:0] pick_id();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return $urandom;
         default: return 32'($urandom_range(0, 23)) - 32'd12;
      endcase
   endfunction

   function automatic logic [63:0] pick_wide();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [31:0] pick_narrow();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Receiver side: random stalls, plus one long hold when the stimulus asks for it.
   initial begin
      int unsigned stall_left;
      stall_left    = 0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap();
         end
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken. Valid
   // stays high on return so that back-to-back beats need no second assignment in a step.
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                            input logic [31:0] id, input logic [63:0] name_lo,
                            input logic [63:0] name_md, input logic [31:0] name_hi,
                            input logic [31:0] score);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.position   <= pos;
      req_ch.record_id  <= id;
      req_ch.name_low   <= name_lo;
      req_ch.name_mid   <= name_md;
      req_ch.name_high  <= name_hi;
      req_ch.score_bits <= score;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      case (kind)
         KIND_APPEND: if (list_size < CAPACITY) list_size++;
         KIND_INSERT: if (list_size < CAPACITY && pos >= 1 && pos <= list_size + 1) list_size++;
         KIND_DELETE: if (pos >= 1 && pos <= list_size) list_size--;
         default: ;
      endcase
   endtask

   task automatic send_simple(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [31:0] id);
      send_item(kind, pos, id, pick_wide(), pick_wide(), pick_narrow(), pick_narrow());
   endtask

   // Random request; grow_pct and drop_pct steer the list size up or down.
   task automatic send_mixed(input int unsigned grow_pct, input int unsigned drop_pct);
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  pos;
      int unsigned       roll;
      int                top_pos;
      roll = $urandom_range(0, 99);
      if (roll < grow_pct) begin
         kind = $urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT;
      end else if (roll < grow_pct + drop_pct) begin
         kind = KIND_DELETE;
      end else if (roll < grow_pct + drop_pct + 20) begin
         kind = KIND_LOCATE;
      end else if (roll < 97) begin
         kind = KIND_READ;
      end else begin
         kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      end
      top_pos = (kind == KIND_INSERT) ? list_size + 1 : list_size;
      if (top_pos < 1) top_pos = 1;
      if ($urandom_range(0, 9) < 8) begin
         pos = POS_W'($urandom_range(1, top_pos));
      end else begin
         pos = POS_W'($urandom);
      end
      send_simple(kind, pos, pick_id());
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (replies_owed != 0) @(negedge clock);
   endtask

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.kind       = KIND_APPEND;
      req_ch.position   = '0;
      req_ch.record_id  = '0;
      req_ch.name_low   = '0;
      req_ch.name_mid   = '0;
      req_ch.name_high  = '0;
      req_ch.score_bits = '0;
      list_size         = 0;
      calm              = 1'b0;
      hold_request      = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Empty list first: every position out of range, nothing found; then a short list.
      send_simple(KIND_READ, 8'd1, 32'd0);
      send_simple(KIND_DELETE, 8'd1, 32'd0);
      send_simple(KIND_LOCATE, 8'd0, 32'd0);
      send_simple(KIND_INSERT, 8'd0, 32'd5);
      send_simple(KIND_INSERT, 8'd2, 32'd5);
      send_item(KIND_APPEND, 8'd0, 32'h8000_0000, '1, '1, '1, '1);
      send_item(KIND_APPEND, 8'd255, 32'h7FFF_FFFF, '0, '0, '0, '0);
      send_simple(KIND_INSERT, 8'd1, 32'hFFFF_FFFF);
      send_simple(KIND_INSERT, 8'd4, 32'd0);
      send_simple(KIND_INSERT, 8'd2, 32'd1);
      for (int p = 1; p <= 5; p++) begin
         send_simple(KIND_READ, POS_W'(p), 32'd0);
      end
      send_simple(KIND_LOCATE, 8'd0, 32'hFFFF_FFFF);
      send_simple(KIND_LOCATE, 8'd255, 32'h8000_0000);
      send_simple(KIND_LOCATE, 8'd7, 32'd12345);
      send_simple(KIND_READ, 8'd255, 32'd0);
      send_simple(KIND_READ, 8'd0, 32'd0);
      send_simple(KIND_SPARE_LO, 8'd255, 32'hFFFF_FFFF);
      send_simple(3'd6, 8'd3, 32'd0);
      send_simple(KIND_SPARE_HI, 8'd0, 32'h8000_0000);
      send_simple(KIND_DELETE, 8'd5, 32'd0);
      send_simple(KIND_DELETE, 8'd1, 32'd0);
      send_simple(KIND_DELETE, 8'd0, 32'd0);

      repeat (130) send_mixed(35, 25);
      wait_idle();

      // Fill the list to capacity, then probe the edges of a full list.
      while (list_size < CAPACITY) send_mixed(80, 0);
      send_simple(KIND_APPEND, 8'd0, pick_id());
      send_simple(KIND_INSERT, 8'd1, pick_id());
      send_simple(KIND_INSERT, 8'd255, pick_id());
      send_simple(KIND_READ, 8'd128, 32'd0);
      send_simple(KIND_READ, 8'd129, 32'd0);
      send_simple(KIND_LOCATE, 8'd0, pick_id());
      send_simple(KIND_DELETE, 8'd128, 32'd0);
      send_simple(KIND_INSERT, 8'd128, pick_id());
      send_simple(KIND_DELETE, 8'd1, 32'd0);
      send_simple(KIND_INSERT, 8'd1, pick_id());
      wait_idle();

      // The receiver holds off long enough that the block backs up onto its input.
      hold_request <= LONG_HOLD_CYCLES;
      repeat (200) send_mixed(10, 45);

      calm <= 1'b1;
      repeat (60) send_mixed(30, 30);

      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/ort_pkg.sv
rtl/ort_if.sv
rtl/ort_ram.sv
rtl/ort_ctrl.sv
rtl/ordered_record_table_unit.sv
tb/ort_reply_checker.sv
tb/tb_top.sv
